### rtl/pcms_pkg.sv
`default_nettype none
package pcms_pkg;

  localparam int WIN         = 8;
  localparam int MAX_RESULTS = 3;
  localparam int GAP_W       = 6;

  localparam logic [7:0] CH_CR  = 8'h0d;
  localparam logic [7:0] CH_LF  = 8'h0a;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_VT  = 8'h0b;
  localparam logic [7:0] CH_FF  = 8'h0c;

  // Patterns are stored with their first character in the low byte, matching the window.
  localparam logic [23:0] PAT_OBJ    = 24'h6a626f;
  localparam logic [47:0] PAT_ENDOBJ = 48'h6a626f646e65;
  localparam logic [39:0] PAT_EOF    = 40'h464f452525;
  localparam logic [55:0] PAT_SPAN   = 56'h206c6165733c25;

  localparam logic KIND_MARKER = 1'b0;
  localparam logic KIND_SPAN   = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_final;
  } item_t;

  typedef struct packed {
    logic        record_kind;
    logic [31:0] start_offset;
    logic [31:0] end_offset;
    logic        last_of_run;
  } result_t;

  // One classified byte handed from the front end to the window engine.
  typedef struct packed {
    logic [7:0]       data_byte;
    logic             is_final;
    logic             in_doc;
    logic [31:0]      scan;
    logic [31:0]      doc_end;
    logic [GAP_W-1:0] gap;
  } work_t;

  function automatic logic is_ws(input logic [7:0] c);
    is_ws = (c == CH_SP) || (c == CH_TAB) || (c == CH_LF) || (c == CH_VT) ||
            (c == CH_FF) || (c == CH_CR);
  endfunction

endpackage
`default_nettype wire

### rtl/pdf_comment_marker_scanner.sv
`default_nettype none
// Channel  Dir  Handshake                  Payload
// item     in   item_valid / item_ready    pcms_pkg::item_t, one document byte
// result   out  result_valid / result_ready pcms_pkg::result_t, marker or span record
// cfg      in   cfg_valid / cfg_ready      total_length, 32 bits
//
// One byte request is taken per cycle while the work queue has room; the window engine
// retires one window step per cycle while work is queued and the result buffer has room.
// The byte that reaches the document end, or a final byte, holds the engine while the
// window drains.
// rst is synchronous: it clears the queues, the window, depth and total_length.
// A full result buffer stalls the engine; a full work queue drops item_ready.
module pdf_comment_marker_scanner #(
  parameter int DEPTH_BITS  = 16,
  parameter int OFFSET_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [31:0]       cfg_data,
  input  logic              item_valid,
  output logic              item_ready,
  input  pcms_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output pcms_pkg::result_t result
);

  localparam int WORK_W = $bits(pcms_pkg::work_t);
  localparam int RES_W  = $bits(pcms_pkg::result_t);

  pcms_pkg::work_t   work_in;
  pcms_pkg::work_t   work_head;
  logic              work_push;
  logic              work_full;
  logic              work_pop;
  logic              work_empty;
  pcms_pkg::result_t res;
  logic              res_push;
  logic              res_full;
  logic              res_empty;

  pcms_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .work_push  (work_push),
    .work       (work_in),
    .work_full  (work_full)
  );

  pcms_fifo #(
    .WIDTH (WORK_W),
    .DEPTH (4)
  ) u_work_q (
    .clk       (clk),
    .rst       (rst),
    .push      (work_push),
    .push_data (work_in),
    .full      (work_full),
    .pop       (work_pop),
    .pop_data  (work_head),
    .empty     (work_empty)
  );

  pcms_back #(
    .DEPTH_BITS  (DEPTH_BITS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .work_valid (!work_empty),
    .work       (work_head),
    .work_pop   (work_pop),
    .res_push   (res_push),
    .res        (res),
    .res_full   (res_full)
  );

  pcms_fifo #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_res_q (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res),
    .full      (res_full),
    .pop       (result_valid && result_ready),
    .pop_data  (result),
    .empty     (res_empty)
  );

  assign result_valid = !res_empty;

endmodule
`default_nettype wire

### rtl/pcms_fifo.sv
`default_nettype none
module pcms_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == (AW+1)'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (AW+1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

### rtl/pcms_front.sv
`default_nettype none
module pcms_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [31:0]       cfg_data,
  input  logic              item_valid,
  output logic              item_ready,
  input  pcms_pkg::item_t   item,
  output logic              work_push,
  output pcms_pkg::work_t   work,
  input  logic              work_full
);

  logic [31:0] total_length;
  logic [31:0] pos;
  logic [32:0] left;         // total_length - pos, negative if the length shrank mid-document

  logic        in_doc;
  logic [32:0] left_step;
  logic [31:0] pos_step;
  logic        ahead;
  logic        early;
  logic [32:0] gap_full;
  logic        gap_hi;
  logic        gap_lo;
  logic [pcms_pkg::GAP_W-1:0] gap_sat;

  assign cfg_ready  = 1'b1;
  assign item_ready = !work_full;
  assign work_push  = item_valid && item_ready;

  always_comb begin
    in_doc    = !left[32] && (left != '0);
    left_step = left - 33'(in_doc);
    pos_step  = pos + 32'(in_doc);
    ahead     = !left_step[32] && (left_step != '0);
    // A final byte that arrives short of the length ends the document right here.
    early     = item.is_final && ahead;
    gap_full  = early ? '0 : left_step;
    gap_hi    = !gap_full[32] && (gap_full[31:5] != '0);
    gap_lo    = gap_full[32] && !(&gap_full[31:4]);
    if (gap_hi) begin
      gap_sat = 6'sd31;
    end else if (gap_lo) begin
      gap_sat = -6'sd16;
    end else begin
      gap_sat = gap_full[pcms_pkg::GAP_W-1:0];
    end

    work.data_byte = item.data_byte;
    work.is_final  = item.is_final;
    work.in_doc    = in_doc;
    work.scan      = pos_step;
    work.doc_end   = early ? pos_step : total_length;
    work.gap       = gap_sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_length <= '0;
      pos          <= '0;
      left         <= '0;
    end else begin
      if (work_push) begin
        if (item.is_final) begin
          pos  <= '0;
          left <= {1'b0, total_length};
        end else begin
          pos  <= pos_step;
          left <= left_step;
        end
      end
      if (cfg_valid) begin
        total_length <= cfg_data;
        left         <= {1'b0, cfg_data} - {1'b0, pos};
      end
    end
  end

endmodule
`default_nettype wire

### rtl/pcms_back.sv
`default_nettype none
module pcms_back #(
  parameter int DEPTH_BITS  = 16,
  parameter int OFFSET_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              work_valid,
  input  pcms_pkg::work_t   work,
  output logic              work_pop,
  output logic              res_push,
  output pcms_pkg::result_t res,
  input  logic              res_full
);

  localparam int OW = (OFFSET_BITS < 32) ? OFFSET_BITS : 32;
  localparam int WB = 8 * pcms_pkg::WIN;

  // Window state
  logic [WB-1:0]         win;
  logic [3:0]            fill;
  logic [2:0]            skip;
  logic                  in_comment;
  logic [OW-1:0]         comment_start;
  logic [DEPTH_BITS-1:0] nest;
  logic                  mid;
  logic [1:0]            run_count;

  // Result waiting to learn whether it closes its request's run
  logic                  pend_valid;
  logic                  pend_last;
  logic                  pend_kind;
  logic [OW-1:0]         pend_start;
  logic [OW-1:0]         pend_end;

  logic [OW-1:0]         scan;
  logic                  at_end;
  logic [WB-1:0]         w1;
  logic [3:0]            fill1;
  logic [2:0]            skip1;
  logic                  comm1;
  logic                  app_emit;
  logic signed [6:0]     rem;
  logic                  walk;
  logic [pcms_pkg::WIN-1:0] ws;
  logic                  nest_zero;
  logic                  m_obj;
  logic                  m_endobj;
  logic                  m_eof;
  logic                  m_span;
  logic                  span_eol;
  logic [OW-1:0]         pos;
  logic [2:0]            drop;
  logic                  take;
  logic [WB-1:0]         w2;
  logic [3:0]            fill2;
  logic [2:0]            skip2;
  logic                  comm2;
  logic [DEPTH_BITS-1:0] nest2;
  logic [OW-1:0]         cstart2;
  logic                  walk_emit;
  logic                  walk_kind;
  logic [OW-1:0]         walk_end;
  logic                  tail_emit;
  logic                  e_valid;
  logic                  e_kind;
  logic [OW-1:0]         e_start;
  logic [OW-1:0]         e_end;
  logic                  more;
  logic                  done;
  logic                  go;
  logic                  e_fire;

  always_comb begin
    scan   = work.scan[OW-1:0];
    at_end = work.gap[pcms_pkg::GAP_W-1] || (work.gap == '0);

    // The byte joins the window on the first cycle of its request.
    w1       = win;
    fill1    = fill;
    skip1    = skip;
    comm1    = in_comment;
    app_emit = 1'b0;
    if (!mid && work.in_doc) begin
      if (skip != '0) begin
        skip1 = skip - 3'd1;
      end else if (in_comment) begin
        if ((work.data_byte == pcms_pkg::CH_CR) || (work.data_byte == pcms_pkg::CH_LF)) begin
          app_emit  = 1'b1;
          comm1     = 1'b0;
          w1[7:0]   = work.data_byte;
          fill1     = 4'd1;
        end
      end else if (fill < 4'(pcms_pkg::WIN)) begin
        w1[{fill[2:0], 3'b000} +: 8] = work.data_byte;
        fill1 = fill + 4'd1;
      end
    end

    // One window step: distance to the document end decides which patterns may fire.
    rem  = $signed({work.gap[pcms_pkg::GAP_W-1], work.gap}) + $signed({3'b000, fill1});
    walk = !comm1 && (skip1 == '0) && (fill1 != '0) && ((fill1 >= 4'd7) || at_end);
    for (int i = 0; i < pcms_pkg::WIN; i++) begin
      ws[i] = (4'(i) < fill1) && pcms_pkg::is_ws(w1[8*i +: 8]);
    end
    nest_zero = (nest == '0);
    m_obj     = (rem > 7'sd5) && ws[0] && (w1[31:8] == pcms_pkg::PAT_OBJ) && ws[4];
    m_endobj  = (rem > 7'sd6) && (fill1 >= 4'd6) && (w1[47:0] == pcms_pkg::PAT_ENDOBJ) && ws[6];
    m_eof     = nest_zero && (rem >= 7'sd5) && (fill1 >= 4'd5) &&
                (w1[39:0] == pcms_pkg::PAT_EOF) && ((rem <= 7'sd5) || ws[5]);
    m_span    = nest_zero && (rem > 7'sd23) && (fill1 >= 4'd7) &&
                (w1[55:0] == pcms_pkg::PAT_SPAN);
    // The pattern itself holds no line end, so only the eighth byte can close the span.
    span_eol  = (fill1 == 4'd8) &&
                ((w1[63:56] == pcms_pkg::CH_CR) || (w1[63:56] == pcms_pkg::CH_LF));
    pos       = scan - OW'(fill1);

    w2        = w1;
    fill2     = fill1;
    skip2     = skip1;
    comm2     = comm1;
    nest2     = nest;
    cstart2   = comment_start;
    walk_emit = 1'b0;
    walk_kind = pcms_pkg::KIND_MARKER;
    walk_end  = pos;
    drop      = 3'd1;
    take      = 1'b1;
    if (walk) begin
      if (m_obj) begin
        drop = 3'd5;
        if (nest != '1) begin
          nest2 = nest + DEPTH_BITS'(1);
        end
      end else if (m_endobj) begin
        drop = 3'd7;
        if (!nest_zero) begin
          nest2 = nest - DEPTH_BITS'(1);
        end
      end else if (m_eof) begin
        drop      = 3'd6;
        walk_emit = 1'b1;
        walk_kind = pcms_pkg::KIND_MARKER;
        walk_end  = pos;
      end else if (m_span) begin
        if (span_eol) begin
          drop      = 3'd7;
          walk_emit = 1'b1;
          walk_kind = pcms_pkg::KIND_SPAN;
          walk_end  = scan - OW'(1);
        end else begin
          take    = 1'b0;
          comm2   = 1'b1;
          fill2   = '0;
          cstart2 = pos;
        end
      end
      if (take) begin
        if ({1'b0, drop} >= fill1) begin
          skip2 = 3'(4'(drop) - fill1);
          fill2 = '0;
        end else begin
          w2    = w1 >> {drop, 3'b000};
          fill2 = fill1 - 4'(drop);
        end
      end
    end

    // An open comment that reaches the document end closes there.
    tail_emit = comm1 && at_end;
    if (tail_emit) begin
      comm2 = 1'b0;
    end

    e_valid = app_emit || walk_emit || tail_emit;
    if (app_emit) begin
      e_kind  = pcms_pkg::KIND_SPAN;
      e_start = comment_start;
      e_end   = scan - OW'(1);
    end else if (walk_emit) begin
      e_kind  = walk_kind;
      e_start = pos;
      e_end   = walk_end;
    end else begin
      e_kind  = pcms_pkg::KIND_SPAN;
      e_start = comment_start;
      e_end   = work.doc_end[OW-1:0];
    end

    more = !comm2 && (skip2 == '0) && (fill2 != '0) && ((fill2 >= 4'd7) || at_end);
    done = !more;
  end

  assign go       = work_valid && !res_full;
  assign e_fire   = go && e_valid && (run_count < 2'(pcms_pkg::MAX_RESULTS));
  assign work_pop = go && done;
  assign res_push = pend_valid && !res_full && (pend_last || e_fire);

  always_comb begin
    res.record_kind  = pend_kind;
    res.start_offset = 32'(pend_start);
    res.end_offset   = 32'(pend_end);
    res.last_of_run  = pend_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      skip       <= '0;
      in_comment <= 1'b0;
      nest       <= '0;
      mid        <= 1'b0;
      run_count  <= '0;
      pend_valid <= 1'b0;
      pend_last  <= 1'b0;
    end else begin
      if (go) begin
        if (done && work.is_final) begin
          fill       <= '0;
          skip       <= '0;
          in_comment <= 1'b0;
          nest       <= '0;
        end else begin
          fill       <= fill2;
          skip       <= skip2;
          in_comment <= comm2;
          nest       <= nest2;
        end
        mid       <= !done;
        run_count <= done ? 2'd0 : run_count + 2'(e_fire);
      end
      if (e_fire) begin
        pend_valid <= 1'b1;
        pend_last  <= done;
      end else if (res_push) begin
        pend_valid <= 1'b0;
      end else if (go && done && pend_valid) begin
        pend_last <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      win           <= w2;
      comment_start <= cstart2;
    end
    if (e_fire) begin
      pend_kind  <= e_kind;
      pend_start <= e_start;
      pend_end   <= e_end;
    end
  end

`ifndef ASSERT_OFF
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= 4'(pcms_pkg::WIN))
    else $error("window fill out of range");
  a_skip_empty: assert property (@(posedge clk) disable iff (rst)
    (skip != '0) |-> (fill == '0))
    else $error("bytes skipped while window holds data");
  a_comment_empty: assert property (@(posedge clk) disable iff (rst)
    in_comment |-> ((fill == '0) && (skip == '0)))
    else $error("comment line open with window or skip active");
  a_open_pend: assert property (@(posedge clk) disable iff (rst)
    (pend_valid && !pend_last) |-> mid)
    else $error("open result held with no request in progress");
  a_final_clear: assert property (@(posedge clk) disable iff (rst)
    (work_pop && work.is_final) |=> ((fill == '0) && !in_comment && (nest == '0)))
    else $error("state not cleared after final byte");
`endif

endmodule
`default_nettype wire

### bench/pdf_comment_marker_scanner_test.sv
module pdf_comment_marker_scanner_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 500000;
  localparam longint unsigned DEPTH_MAX = 65535;

  typedef enum {TOK_OBJ, TOK_ENDOBJ, TOK_MARKER, TOK_SPAN, TOK_NOISE, TOK_SPACE} token_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [31:0] cfg_data = '0;
  logic item_valid = 1'b0;
  logic item_ready;
  pcms_pkg::item_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  pcms_pkg::result_t result;

  pdf_comment_marker_scanner dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  always #1 clk = ~clk;

  // Handshake flags captured at the rising edge, read by the falling-edge drivers.
  logic item_took = 1'b0;
  logic result_took = 1'b0;
  logic cfg_took = 1'b0;

  pcms_pkg::item_t byte_requests[$];
  pcms_pkg::result_t awaited_records[$];
  logic [7:0] doc_bytes[$];
  int error_count = 0;
  int items_sent = 0;
  int cycle_count = 0;
  bit calm = 1'b0;
  bit want_hold = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int item_wait = 0;
  int ready_wait = 0;

  // Scanner state as the block should hold it.
  logic [7:0] look_bytes[0:7];
  int unsigned look_fill;
  int unsigned skip_left;
  longint unsigned walk_pos;
  longint unsigned obj_depth;
  longint unsigned span_start;
  longint unsigned doc_length;
  bit in_span;
  pcms_pkg::result_t step_recs[0:2];
  int step_n;

  function automatic int pick_gap();
    return calm ? 0 : $urandom_range(0, 12);
  endfunction

  function automatic bit is_space(logic [7:0] c);
    case (c)
      8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit look_space(int unsigned idx);
    return idx < look_fill && is_space(look_bytes[idx]);
  endfunction

  function automatic bit look_has(int unsigned off, logic [55:0] pat, int unsigned len);
    if (off + len > look_fill) return 1'b0;
    for (int unsigned i = 0; i < len; i++) begin
      if (look_bytes[off + i] != pat[8 * i +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic clear_scan();
    foreach (look_bytes[i]) look_bytes[i] = 8'h00;
    look_fill = 0;
    skip_left = 0;
    walk_pos = 0;
    obj_depth = 0;
    span_start = 0;
    in_span = 1'b0;
  endtask

  task automatic note_record(logic kind, longint unsigned s, longint unsigned e);
    if (step_n < pcms_pkg::MAX_RESULTS) begin
      step_recs[step_n].record_kind = kind;
      step_recs[step_n].start_offset = s[31:0];
      step_recs[step_n].end_offset = e[31:0];
      step_recs[step_n].last_of_run = 1'b0;
      step_n++;
    end
  endtask

  task automatic shift_look(int unsigned k);
    if (k >= look_fill) begin
      skip_left += k - look_fill;
      look_fill = 0;
    end else begin
      for (int unsigned i = 0; i < look_fill - k; i++) look_bytes[i] = look_bytes[i + k];
      look_fill -= k;
    end
  endtask

  task automatic walk_window(longint unsigned doc_end);
    longint unsigned pos;
    int unsigned k;
    while (!in_span && skip_left == 0 && look_fill > 0 &&
           (look_fill >= 7 || walk_pos >= doc_end)) begin
      pos = walk_pos - look_fill;
      if (pos + 5 < doc_end && look_space(0) && look_has(1, 56'(pcms_pkg::PAT_OBJ), 3) &&
          look_space(4)) begin
        if (obj_depth < DEPTH_MAX) obj_depth++;
        shift_look(5);
      end else if (pos + 6 < doc_end && look_has(0, 56'(pcms_pkg::PAT_ENDOBJ), 6) &&
                   look_space(6)) begin
        if (obj_depth > 0) obj_depth--;
        shift_look(7);
      end else if (obj_depth == 0 && pos + 5 <= doc_end &&
                   look_has(0, 56'(pcms_pkg::PAT_EOF), 5) &&
                   (pos + 5 >= doc_end || look_space(5))) begin
        note_record(pcms_pkg::KIND_MARKER, pos, pos);
        shift_look(6);
      end else if (obj_depth == 0 && pos + 23 < doc_end &&
                   look_has(0, pcms_pkg::PAT_SPAN, 7)) begin
        k = 1;
        while (k < look_fill && look_bytes[k] != pcms_pkg::CH_CR &&
               look_bytes[k] != pcms_pkg::CH_LF) k++;
        if (k < look_fill) begin
          note_record(pcms_pkg::KIND_SPAN, pos, pos + k);
          shift_look(k);
        end else begin
          // The line runs past the window; the rest is consumed byte by byte.
          span_start = pos;
          in_span = 1'b1;
          look_fill = 0;
        end
      end else begin
        shift_look(1);
      end
    end
  endtask

  task automatic predict_records(pcms_pkg::item_t it);
    longint unsigned doc_end;
    longint unsigned here;
    step_n = 0;
    if (walk_pos < doc_length) begin
      here = walk_pos;
      walk_pos++;
      if (skip_left > 0) begin
        skip_left--;
      end else if (in_span) begin
        if (it.data_byte == pcms_pkg::CH_CR || it.data_byte == pcms_pkg::CH_LF) begin
          note_record(pcms_pkg::KIND_SPAN, span_start, here);
          in_span = 1'b0;
          look_bytes[0] = it.data_byte;
          look_fill = 1;
        end
      end else if (look_fill < pcms_pkg::WIN) begin
        look_bytes[look_fill] = it.data_byte;
        look_fill++;
      end
    end
    // An early final byte shortens the document for this drain only.
    doc_end = doc_length;
    if (it.is_final && walk_pos < doc_end) doc_end = walk_pos;
    walk_window(doc_end);
    if (in_span && walk_pos >= doc_end) begin
      note_record(pcms_pkg::KIND_SPAN, span_start, doc_end);
      in_span = 1'b0;
    end
    if (it.is_final) clear_scan();
    for (int i = 0; i < step_n; i++) begin
      if (i == step_n - 1) step_recs[i].last_of_run = 1'b1;
      awaited_records.push_back(step_recs[i]);
    end
  endtask

  task automatic check_field(string what, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      error_count++;
      $display("%0t: %s expected %0d, actual %0d", $time, what, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    pcms_pkg::result_t want;
    item_took <= !rst && item_valid && item_ready;
    result_took <= !rst && result_valid && result_ready;
    cfg_took <= !rst && cfg_valid && cfg_ready;
    if (rst) begin
      clear_scan();
      doc_length = 0;
    end else begin
      if (result_valid && result_ready) begin
        if (awaited_records.size() == 0) begin
          error_count++;
          $display("%0t: record expected none, actual kind %0d start %0d end %0d",
                   $time, result.record_kind, result.start_offset, result.end_offset);
        end else begin
          want = awaited_records.pop_front();
          check_field("record_kind", 32'(want.record_kind), 32'(result.record_kind));
          check_field("start_offset", want.start_offset, result.start_offset);
          check_field("end_offset", want.end_offset, result.end_offset);
          check_field("last_of_run", 32'(want.last_of_run), 32'(result.last_of_run));
        end
      end
      if (item_valid && item_ready) predict_records(item);
      if (cfg_valid && cfg_ready) doc_length = 64'(cfg_data);
    end
  end

  always @(negedge clk) begin
    int w;
    w = item_wait;
    if (rst) begin
      item_valid <= 1'b0;
      item_wait <= 0;
    end else if (!(item_valid && !item_took)) begin
      if (item_valid && item_took) w = pick_gap();
      if (w > 0) begin
        item_valid <= 1'b0;
        w--;
      end else if (byte_requests.size() != 0) begin
        item_valid <= 1'b1;
        item <= byte_requests.pop_front();
      end else begin
        item_valid <= 1'b0;
      end
      item_wait <= w;
    end
  end

  always @(negedge clk) begin
    int w;
    w = ready_wait;
    if (rst) begin
      result_ready <= 1'b0;
      ready_wait <= 0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      result_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (want_hold && !hold_done) begin
      // One long stall so that the result path backs up into the input.
      result_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      if (result_took) w = pick_gap();
      if (w > 0) begin
        result_ready <= 1'b0;
        w--;
      end else begin
        result_ready <= 1'b1;
      end
      ready_wait <= w;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic settle();
    while (byte_requests.size() != 0 || item_valid) @(negedge clk);
    while (awaited_records.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_length(logic [31:0] value);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(negedge clk); while (!cfg_took);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_pattern(logic [55:0] pat, int len);
    for (int i = 0; i < len; i++) doc_bytes.push_back(pat[8 * i +: 8]);
  endtask

  task automatic add_space();
    case ($urandom_range(0, 5))
      0: doc_bytes.push_back(pcms_pkg::CH_SP);
      1: doc_bytes.push_back(pcms_pkg::CH_TAB);
      2: doc_bytes.push_back(pcms_pkg::CH_LF);
      3: doc_bytes.push_back(pcms_pkg::CH_VT);
      4: doc_bytes.push_back(pcms_pkg::CH_FF);
      default: doc_bytes.push_back(pcms_pkg::CH_CR);
    endcase
  endtask

  task automatic add_token(token_t kind);
    int n;
    case (kind)
      TOK_OBJ: begin
        add_space();
        add_pattern(56'(pcms_pkg::PAT_OBJ), 3);
        add_space();
      end
      TOK_ENDOBJ: begin
        add_pattern(56'(pcms_pkg::PAT_ENDOBJ), 6);
        add_space();
      end
      TOK_MARKER: begin
        add_pattern(56'(pcms_pkg::PAT_EOF), 5);
        if ($urandom_range(0, 3) != 0) add_space();
      end
      TOK_SPAN: begin
        add_pattern(pcms_pkg::PAT_SPAN, 7);
        n = $urandom_range(0, 20);
        repeat (n) doc_bytes.push_back(8'($urandom_range(8'h20, 8'h7e)));
        case ($urandom_range(0, 5))
          0: ;
          1, 2: doc_bytes.push_back(pcms_pkg::CH_CR);
          default: doc_bytes.push_back(pcms_pkg::CH_LF);
        endcase
      end
      TOK_NOISE: begin
        n = $urandom_range(1, 4);
        repeat (n) doc_bytes.push_back(8'($urandom_range(0, 255)));
      end
      default: add_space();
    endcase
  endtask

  task automatic build_document();
    int tokens;
    token_t kind;
    doc_bytes.delete();
    tokens = $urandom_range(3, 9);
    repeat (tokens) begin
      case ($urandom_range(0, 8))
        0: kind = TOK_OBJ;
        1: kind = TOK_ENDOBJ;
        2, 3: kind = TOK_MARKER;
        4, 5: kind = TOK_SPAN;
        6, 7: kind = TOK_NOISE;
        default: kind = TOK_SPACE;
      endcase
      add_token(kind);
    end
  endtask

  task automatic send_document();
    pcms_pkg::item_t it;
    foreach (doc_bytes[i]) begin
      it.data_byte = doc_bytes[i];
      it.is_final = (i == doc_bytes.size() - 1);
      byte_requests.push_back(it);
    end
    items_sent += doc_bytes.size();
  endtask

  initial begin
    int phase;
    int extra;
    logic [31:0] len;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Zero length: every byte lies past the end and is ignored.
    doc_bytes.delete();
    doc_bytes.push_back(8'h00);
    doc_bytes.push_back(8'hff);
    write_length(32'd0);
    send_document();

    // Largest length with an early final byte: the marker sits right at the end.
    settle();
    doc_bytes.delete();
    add_pattern(56'(pcms_pkg::PAT_EOF), 5);
    write_length(32'hffffffff);
    send_document();

    // A span line that never ends runs to the document end; one byte past it follows.
    settle();
    doc_bytes.delete();
    add_pattern(pcms_pkg::PAT_SPAN, 7);
    doc_bytes.push_back(8'h00);
    doc_bytes.push_back(8'hff);
    repeat (15) doc_bytes.push_back(8'($urandom_range(8'h20, 8'h7e)));
    doc_bytes.push_back(8'h80);
    write_length(32'd24);
    send_document();

    phase = 0;
    while ((items_sent < 350 || phase < 2) && phase < 60) begin
      settle();
      calm = (phase % 4 == 3);
      if (phase == 1) begin
        // Dense markers while the result side stalls for a long time.
        calm = 1'b1;
        want_hold = 1'b1;
        doc_bytes.delete();
        repeat (12) add_token(TOK_MARKER);
        add_space();
        len = 32'(doc_bytes.size());
      end else begin
        build_document();
        case ($urandom_range(0, 5))
          0, 1, 2: len = 32'(doc_bytes.size());
          3: len = 32'(doc_bytes.size()) + 32'($urandom_range(1, 20));
          4: len = $urandom_range(0, doc_bytes.size());
          default: len = 32'hffffffff;
        endcase
      end
      write_length(len);
      send_document();
      extra = $urandom_range(0, 2);
      repeat (extra) begin
        build_document();
        send_document();
      end
      phase++;
    end

    settle();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### files.f
rtl/pcms_pkg.sv
rtl/pcms_fifo.sv
rtl/pcms_front.sv
rtl/pcms_back.sv
rtl/pdf_comment_marker_scanner.sv
bench/pdf_comment_marker_scanner_test.sv
